FILE: design/drlm_pkg.sv
package drlm_pkg;

  localparam int XY_W    = 13;
  localparam int WH_W    = 14;
  localparam int IN_W    = 16;
  localparam int COORD_W = 18;
  localparam int SIZE_W  = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_MARK_ALL = 1'b1;

  typedef struct packed {
    logic                   op;
    logic signed [IN_W-1:0] in_x;
    logic signed [IN_W-1:0] in_y;
    logic signed [IN_W-1:0] in_width;
    logic signed [IN_W-1:0] in_height;
  } in_item_t;

  typedef struct packed {
    logic [XY_W-1:0]   out_x;
    logic [XY_W-1:0]   out_y;
    logic [WH_W-1:0]   out_width;
    logic [WH_W-1:0]   out_height;
    logic [SIZE_W-1:0] list_size;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [WH_W-1:0] w;
    logic [WH_W-1:0] h;
  } rect_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
  } box_t;

  typedef enum logic {
    UOP_CLIP,
    UOP_JOIN
  } uop_t;

  function automatic box_t rect_to_box(rect_t r);
    box_t b;
    b.x = $signed({{(COORD_W-XY_W){1'b0}}, r.x});
    b.y = $signed({{(COORD_W-XY_W){1'b0}}, r.y});
    b.w = $signed({{(COORD_W-WH_W){1'b0}}, r.w});
    b.h = $signed({{(COORD_W-WH_W){1'b0}}, r.h});
    return b;
  endfunction

  function automatic rect_t box_to_rect(box_t b);
    rect_t r;
    r.x = b.x[XY_W-1:0];
    r.y = b.y[XY_W-1:0];
    r.w = b.w[WH_W-1:0];
    r.h = b.h[WH_W-1:0];
    return r;
  endfunction

  function automatic box_t in_to_box(in_item_t i);
    box_t b;
    b.x = {{(COORD_W-IN_W){i.in_x[IN_W-1]}}, i.in_x};
    b.y = {{(COORD_W-IN_W){i.in_y[IN_W-1]}}, i.in_y};
    b.w = {{(COORD_W-IN_W){i.in_width[IN_W-1]}}, i.in_width};
    b.h = {{(COORD_W-IN_W){i.in_height[IN_W-1]}}, i.in_height};
    return b;
  endfunction

endpackage

FILE: design/drlm_box_unit.sv
module drlm_box_unit (
  input  drlm_pkg::box_t a,
  input  drlm_pkg::box_t b,
  input  drlm_pkg::uop_t uop,
  output drlm_pkg::box_t res,
  output logic           touch
);

  localparam int W = drlm_pkg::COORD_W;

  logic signed [W-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic signed [W-1:0] ax1, ay1, bx1, by1;
  logic signed [W-1:0] lox, loy, hix, hiy, mnx, mny, mxx, mxy;
  logic                a_empty, b_empty;

  assign ax = a.x;
  assign ay = a.y;
  assign aw = a.w;
  assign ah = a.h;
  assign bx = b.x;
  assign by = b.y;
  assign bw = b.w;
  assign bh = b.h;

  assign ax1 = ax + aw;
  assign ay1 = ay + ah;
  assign bx1 = bx + bw;
  assign by1 = by + bh;

  assign a_empty = aw[W-1] || (aw == '0) || ah[W-1] || (ah == '0);
  assign b_empty = bw[W-1] || (bw == '0) || bh[W-1] || (bh == '0);

  assign lox = (ax > bx) ? ax : bx;
  assign loy = (ay > by) ? ay : by;
  assign hix = (ax1 < bx1) ? ax1 : bx1;
  assign hiy = (ay1 < by1) ? ay1 : by1;
  assign mnx = (ax < bx) ? ax : bx;
  assign mny = (ay < by) ? ay : by;
  assign mxx = (ax1 > bx1) ? ax1 : bx1;
  assign mxy = (ay1 > by1) ? ay1 : by1;

  assign touch = !a_empty && !b_empty && (ax <= bx1) && (bx <= ax1) &&
                 (ay <= by1) && (by <= ay1);

  always_comb begin
    res = '0;
    if (uop == drlm_pkg::UOP_CLIP) begin
      if (!((hix <= lox) || (hiy <= loy))) begin
        res.x = lox;
        res.y = loy;
        res.w = hix - lox;
        res.h = hiy - loy;
      end
    end else begin
      if (a_empty) begin
        res = b;
      end else if (b_empty) begin
        res = a;
      end else begin
        res.x = mnx;
        res.y = mny;
        res.w = mxx - mnx;
        res.h = mxy - mny;
      end
    end
  end

endmodule

FILE: design/dirty_rect_list_merger.sv
// Dirty rectangle list with merging.
// The input channel (in_valid, in_ready, in_data) takes one item at a time:
// op 0 adds a damage rectangle, op 1 marks the whole screen. An added
// rectangle is clipped to the screen, then merged with every stored entry it
// touches, restarting the slot scan after each merge, and finally appended or
// collapsed with all entries into one when the list is full.
// After each item the output channel (out_valid, out_ready, out_data) gives
// one transfer per stored rectangle in slot order, or one all-zero transfer
// when the list is empty; last marks the final transfer of the item.
// The configuration channel writes screen_width (index 0) and screen_height
// (index 1) and is always ready; other indexes are ignored.
// A scan reads, then compares each slot it visits; a merge adds a write-back of
// the last entry; a collapse reads and joins every slot; each emitted rectangle
// is read, then loaded; all as set by the single read port of the rectangle
// memory and the shared box unit. in_ready is high only while the sequencer is idle.
// A stalled receiver holds the output register and halts the emission.
// Synchronous reset empties the list and restores a 320 by 240 screen.
module dirty_rect_list_merger #(
  parameter int MAX_RECTS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  drlm_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output drlm_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [drlm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [drlm_pkg::XY_W-1:0]            cfg_data
);

  localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLIP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_LAST_WR,
    S_COL_RD,
    S_COL_JOIN,
    S_COL_CLIP,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    cnt_m1;
  drlm_pkg::box_t      r_r, r_nxt;
  logic                out_valid_r, out_valid_nxt;
  drlm_pkg::out_item_t out_data_r, out_data_nxt;
  logic [drlm_pkg::XY_W-1:0] screen_w_r, screen_h_r;

  drlm_pkg::rect_t     mem [MAX_RECTS];
  drlm_pkg::rect_t     rd_data_r;
  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  drlm_pkg::rect_t     wr_data;

  drlm_pkg::box_t      ua, ub, ures, scr_box;
  drlm_pkg::uop_t      uop;
  logic                utouch;
  logic                slot_free;

  drlm_box_unit u_box (
    .a     (ua),
    .b     (ub),
    .uop   (uop),
    .res   (ures),
    .touch (utouch)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cnt_m1    = count_r - CNT_W'(1);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    scr_box   = '0;
    scr_box.w = $signed({{(drlm_pkg::COORD_W-drlm_pkg::XY_W){1'b0}}, screen_w_r});
    scr_box.h = $signed({{(drlm_pkg::COORD_W-drlm_pkg::XY_W){1'b0}}, screen_h_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= drlm_pkg::XY_W'(320);
      screen_h_r <= drlm_pkg::XY_W'(240);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == drlm_pkg::REG_SCREEN_WIDTH) begin
        screen_w_r <= cfg_data;
      end else if (cfg_index == drlm_pkg::REG_SCREEN_HEIGHT) begin
        screen_h_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_data       = drlm_pkg::box_to_rect(ures);
    rd_en         = 1'b0;
    rd_addr       = idx_r[IDX_W-1:0];
    ua            = r_r;
    ub            = scr_box;
    uop           = drlm_pkg::UOP_CLIP;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.op == drlm_pkg::OP_MARK_ALL) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = drlm_pkg::box_to_rect(scr_box);
            count_nxt = CNT_W'(1);
            idx_nxt   = '0;
            state_nxt = S_EMIT_RD;
          end else begin
            r_nxt     = drlm_pkg::in_to_box(in_data);
            state_nxt = S_CLIP;
          end
        end
      end
      S_CLIP: begin
        idx_nxt = '0;
        if (ures.w == '0) begin
          state_nxt = S_EMIT_RD;
        end else begin
          r_nxt     = ures;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_r < count_r) begin
          rd_en     = 1'b1;
          state_nxt = S_SCAN_CMP;
        end else if (count_r < CNT_W'(MAX_RECTS)) begin
          wr_en     = 1'b1;
          wr_addr   = count_r[IDX_W-1:0];
          wr_data   = drlm_pkg::box_to_rect(r_r);
          count_nxt = count_r + CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_COL_RD;
        end
      end
      S_SCAN_CMP: begin
        ua  = drlm_pkg::rect_to_box(rd_data_r);
        ub  = r_r;
        uop = drlm_pkg::UOP_JOIN;
        if (utouch) begin
          r_nxt     = ures;
          rd_en     = 1'b1;
          rd_addr   = cnt_m1[IDX_W-1:0];
          state_nxt = S_LAST_WR;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_LAST_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data_r;
        count_nxt = cnt_m1;
        idx_nxt   = '0;
        state_nxt = S_SCAN_RD;
      end
      S_COL_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_COL_JOIN;
      end
      S_COL_JOIN: begin
        ub      = drlm_pkg::rect_to_box(rd_data_r);
        uop     = drlm_pkg::UOP_JOIN;
        r_nxt   = ures;
        idx_nxt = idx_r + CNT_W'(1);
        if (idx_r == CNT_W'(MAX_RECTS - 1)) begin
          state_nxt = S_COL_CLIP;
        end else begin
          state_nxt = S_COL_RD;
        end
      end
      S_COL_CLIP: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        count_nxt = CNT_W'(1);
        idx_nxt   = '0;
        state_nxt = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        if (count_r == '0) begin
          if (slot_free) begin
            out_valid_nxt     = 1'b1;
            out_data_nxt      = '0;
            out_data_nxt.last = 1'b1;
            state_nxt         = S_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_x      = rd_data_r.x;
          out_data_nxt.out_y      = rd_data_r.y;
          out_data_nxt.out_width  = rd_data_r.w;
          out_data_nxt.out_height = rd_data_r.h;
          out_data_nxt.list_size  = drlm_pkg::SIZE_W'(count_r);
          out_data_nxt.last       = (idx_r == cnt_m1);
          idx_nxt                 = idx_r + CNT_W'(1);
          state_nxt               = (idx_r == cnt_m1) ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    r_r        <= r_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECTS))
    else $error("rectangle count above capacity");

  a_mark_all: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.op == drlm_pkg::OP_MARK_ALL)) |=>
      (count_r == CNT_W'(1)))
    else $error("mark-all did not leave a single entry");

  a_mem_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en |-> (wr_addr <= IDX_W'(MAX_RECTS - 1))) and
    (rd_en |-> (rd_addr <= IDX_W'(MAX_RECTS - 1))))
    else $error("memory address beyond capacity");

  a_scan_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CMP) |-> (idx_r < count_r))
    else $error("scan compared a slot beyond the list");

  a_last_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_data_r.last) |-> (out_data_r.list_size > 6'd1))
    else $error("non-final transfer in a list of one or none");

endmodule

FILE: test/dirty_rect_list_merger_test.sv
module dirty_rect_list_merger_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RECTS = 8;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam logic [drlm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = drlm_pkg::CFG_IDX_W'(2);
  localparam logic [drlm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = drlm_pkg::CFG_IDX_W'(3);

  typedef struct packed {
    int x;
    int y;
    int w;
    int h;
  } area_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                           kind;
    drlm_pkg::in_item_t                  item;
    logic [drlm_pkg::CFG_IDX_W-1:0]      idx;
    logic [drlm_pkg::XY_W-1:0]           val;
    bit                                  typed;
    drlm_pkg::out_item_t                 want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  drlm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  drlm_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [drlm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [drlm_pkg::XY_W-1:0] cfg_data = '0;

  area_t dmg_list [MAX_RECTS];
  int dmg_count = 0;
  int scr_w = 320;
  int scr_h = 240;
  drlm_pkg::out_item_t pending_rects[$];
  int mismatches = 0;
  int cycles = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  dirty_rect_list_merger #(
    .MAX_RECTS(MAX_RECTS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit area_empty(area_t a);
    return a.w <= 0 || a.h <= 0;
  endfunction

  function automatic area_t screen_area();
    area_t s;
    s.x = 0;
    s.y = 0;
    s.w = scr_w;
    s.h = scr_h;
    return s;
  endfunction

  function automatic area_t clip_area(area_t a, area_t b);
    area_t z;
    int x0, y0, x1, y1;
    z = '0;
    x0 = (a.x > b.x) ? a.x : b.x;
    y0 = (a.y > b.y) ? a.y : b.y;
    x1 = (a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w;
    y1 = (a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h;
    if (x1 <= x0 || y1 <= y0) return z;
    z.x = x0;
    z.y = y0;
    z.w = x1 - x0;
    z.h = y1 - y0;
    return z;
  endfunction

  function automatic area_t join_area(area_t a, area_t b);
    area_t r;
    int x1, y1;
    if (area_empty(a)) return b;
    if (area_empty(b)) return a;
    r.x = (a.x < b.x) ? a.x : b.x;
    r.y = (a.y < b.y) ? a.y : b.y;
    x1 = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
    y1 = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
    r.w = x1 - r.x;
    r.h = y1 - r.y;
    return r;
  endfunction

  function automatic bit areas_touch(area_t a, area_t b);
    if (area_empty(a) || area_empty(b)) return 1'b0;
    return a.x <= b.x + b.w && b.x <= a.x + a.w &&
           a.y <= b.y + b.h && b.y <= a.y + a.h;
  endfunction

  function automatic void add_damage(area_t r);
    area_t scr;
    bit merged;
    int i;
    scr = screen_area();
    r = clip_area(r, scr);
    if (area_empty(r)) return;
    do begin
      merged = 1'b0;
      for (i = 0; i < dmg_count && !merged; i++) begin
        if (areas_touch(dmg_list[i], r)) begin
          r = join_area(dmg_list[i], r);
          dmg_list[i] = dmg_list[dmg_count - 1];
          dmg_count--;
          merged = 1'b1;
        end
      end
    end while (merged);
    if (dmg_count < MAX_RECTS) begin
      dmg_list[dmg_count] = r;
      dmg_count++;
      return;
    end
    for (i = 0; i < MAX_RECTS; i++) r = join_area(r, dmg_list[i]);
    dmg_list[0] = clip_area(r, scr);
    dmg_count = 1;
  endfunction

  function automatic drlm_pkg::out_item_t mk_rect(int x, int y, int w, int h, int size,
                                                  bit last);
    drlm_pkg::out_item_t o;
    o.out_x = drlm_pkg::XY_W'(x);
    o.out_y = drlm_pkg::XY_W'(y);
    o.out_width = drlm_pkg::WH_W'(w);
    o.out_height = drlm_pkg::WH_W'(h);
    o.list_size = drlm_pkg::SIZE_W'(size);
    o.last = last;
    return o;
  endfunction

  function automatic void update_damage_list(drlm_pkg::in_item_t it);
    area_t r;
    int i;
    if (it.op == drlm_pkg::OP_MARK_ALL) begin
      dmg_list[0] = screen_area();
      dmg_count = 1;
    end else begin
      r.x = int'($signed(it.in_x));
      r.y = int'($signed(it.in_y));
      r.w = int'($signed(it.in_width));
      r.h = int'($signed(it.in_height));
      add_damage(r);
    end
    if (dmg_count == 0) begin
      pending_rects.push_back(mk_rect(0, 0, 0, 0, 0, 1'b1));
    end else begin
      for (i = 0; i < dmg_count; i++)
        pending_rects.push_back(mk_rect(dmg_list[i].x, dmg_list[i].y, dmg_list[i].w,
                                        dmg_list[i].h, dmg_count, i == dmg_count - 1));
    end
  endfunction

  function automatic void report_rect(string what, drlm_pkg::out_item_t want,
                                      drlm_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected x=%0d y=%0d w=%0d h=%0d size=%0d last=%0d",
               $realtime, what, want.out_x, want.out_y, want.out_width,
               want.out_height, want.list_size, want.last);
      $display("    got x=%0d y=%0d w=%0d h=%0d size=%0d last=%0d",
               got.out_x, got.out_y, got.out_width, got.out_height,
               got.list_size, got.last);
    end
  endfunction

  function automatic void check_rect(drlm_pkg::out_item_t got);
    drlm_pkg::out_item_t want;
    if (pending_rects.size() == 0) begin
      report_rect("transfer with nothing pending", '0, got);
      return;
    end
    want = pending_rects.pop_front();
    if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
        got.out_width !== want.out_width || got.out_height !== want.out_height ||
        got.list_size !== want.list_size || got.last !== want.last)
      report_rect("rectangle mismatch", want, got);
  endfunction

  function automatic int pick_gap(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic drlm_pkg::in_item_t mk_item(logic op, int x, int y, int w, int h);
    drlm_pkg::in_item_t it;
    it.op = op;
    it.in_x = drlm_pkg::IN_W'(x);
    it.in_y = drlm_pkg::IN_W'(y);
    it.in_width = drlm_pkg::IN_W'(w);
    it.in_height = drlm_pkg::IN_W'(h);
    return it;
  endfunction

  function automatic row_t item_row(drlm_pkg::in_item_t it, bit typed,
                                    drlm_pkg::out_item_t want);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = it;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [drlm_pkg::CFG_IDX_W-1:0] idx, int val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = drlm_pkg::XY_W'(val);
    return r;
  endfunction

  task automatic offer_item(input drlm_pkg::in_item_t it, input bit typed,
                            input drlm_pkg::out_item_t want);
    int gap;
    int before_n;
    if (cfg_valid) cfg_valid <= 1'b0;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (!in_ready);
    before_n = pending_rects.size();
    update_damage_list(it);
    if (typed) begin
      while (pending_rects.size() > before_n) void'(pending_rects.pop_back());
      pending_rects.push_back(want);
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [drlm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [drlm_pkg::XY_W-1:0] val);
    if (in_valid) in_valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    if (idx == drlm_pkg::REG_SCREEN_WIDTH) scr_w = int'(val);
    else if (idx == drlm_pkg::REG_SCREEN_HEIGHT) scr_h = int'(val);
    @(posedge clk);
  endtask

  initial begin : sink
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      gap = pick_gap(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      check_rect(out_data);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    row_t plan[$];
    drlm_pkg::in_item_t it;
    int n;
    int roll;
    int i;

    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 0, 0, 0, 0), 1'b1,
                            mk_rect(0, 0, 0, 0, 0, 1'b1)));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, -32768, -32768, 32767, 32767), 1'b1,
                            mk_rect(0, 0, 0, 0, 0, 1'b1)));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 32767, 32767, -32768, -32768), 1'b1,
                            mk_rect(0, 0, 0, 0, 0, 1'b1)));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, -1, -1, 2, 2), 1'b1,
                            mk_rect(0, 0, 1, 1, 1, 1'b1)));
    for (i = 1; i < MAX_RECTS; i++)
      plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 10 * i, 0, 1, 1), 1'b0, '0));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 100, 100, 1, 1), 1'b0, '0));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 101, 101, 5, 5), 1'b0, '0));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 300, 200, 100, 100), 1'b0, '0));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 106, 0, 194, 1), 1'b0, '0));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 32767, 32767, 32767, 32767),
                            1'b0, '0));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_MARK_ALL, 0, 0, 0, 0), 1'b1,
                            mk_rect(0, 0, 320, 240, 1, 1'b1)));
    plan.push_back(cfg_row(REG_SPARE_A, 8191));
    plan.push_back(cfg_row(REG_SPARE_B, 0));
    plan.push_back(cfg_row(drlm_pkg::REG_SCREEN_WIDTH, 0));
    plan.push_back(cfg_row(drlm_pkg::REG_SCREEN_HEIGHT, 0));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_MARK_ALL, -1, -1, -1, -1), 1'b1,
                            mk_rect(0, 0, 0, 0, 1, 1'b1)));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 0, 0, 10, 10), 1'b1,
                            mk_rect(0, 0, 0, 0, 1, 1'b1)));
    plan.push_back(cfg_row(drlm_pkg::REG_SCREEN_WIDTH, 8191));
    plan.push_back(cfg_row(drlm_pkg::REG_SCREEN_HEIGHT, 8191));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 0, 0, 32767, 32767), 1'b0, '0));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_MARK_ALL, 0, 0, 0, 0), 1'b1,
                            mk_rect(0, 0, 8191, 8191, 1, 1'b1)));
    plan.push_back(item_row(mk_item(drlm_pkg::OP_ADD, 8190, 8190, 1, 1), 1'b0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) write_reg(plan[k].idx, plan[k].val);
      else offer_item(plan[k].item, plan[k].typed, plan[k].want);
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(drlm_pkg::REG_SCREEN_WIDTH, drlm_pkg::XY_W'(320));
          write_reg(drlm_pkg::REG_SCREEN_HEIGHT, drlm_pkg::XY_W'(240));
        end
        1: begin
          write_reg(drlm_pkg::REG_SCREEN_WIDTH, drlm_pkg::XY_W'(8191));
          write_reg(drlm_pkg::REG_SCREEN_HEIGHT, drlm_pkg::XY_W'(8191));
        end
        2: begin
          write_reg(drlm_pkg::REG_SCREEN_WIDTH, drlm_pkg::XY_W'(0));
          write_reg(drlm_pkg::REG_SCREEN_HEIGHT, drlm_pkg::XY_W'($urandom()));
        end
        3: begin
          write_reg(drlm_pkg::REG_SCREEN_WIDTH, drlm_pkg::XY_W'(64));
          write_reg(drlm_pkg::REG_SCREEN_HEIGHT, drlm_pkg::XY_W'(16));
        end
        4: begin
          write_reg(drlm_pkg::REG_SCREEN_WIDTH, drlm_pkg::XY_W'($urandom_range(1, 8191)));
          write_reg(drlm_pkg::REG_SCREEN_HEIGHT, drlm_pkg::XY_W'($urandom_range(1, 8191)));
        end
        default: begin
          write_reg(drlm_pkg::REG_SCREEN_WIDTH, drlm_pkg::XY_W'(1));
          write_reg(drlm_pkg::REG_SCREEN_HEIGHT, drlm_pkg::XY_W'($urandom_range(1, 600)));
        end
      endcase
      n = (p == 2) ? 20 : 96;
      for (int j = 0; j < n; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)
          it = mk_item(drlm_pkg::OP_MARK_ALL, $urandom(), $urandom(), $urandom(),
                       $urandom());
        else if (roll < 14)
          it = mk_item(drlm_pkg::OP_ADD, $urandom(), $urandom(), $urandom(), $urandom());
        else
          it = mk_item(drlm_pkg::OP_ADD, $urandom_range(0, scr_w + 16) - 8,
                       $urandom_range(0, scr_h + 16) - 8,
                       $urandom_range(0, scr_w / 6 + 3) - 1,
                       $urandom_range(0, scr_h / 6 + 3) - 1);
        offer_item(it, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_rects.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
